[rtl/five_point_stencil_sum_unit_defines.svh]
// ----------------------------------------------------------------------------
// Five-point stencil sum unit: assertion macros
// Shared concurrent assertion forms; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef FIVE_POINT_STENCIL_SUM_UNIT_DEFINES_SVH
`define FIVE_POINT_STENCIL_SUM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define FPSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stencil unit assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stencil unit assertion failed");

`else

`define FPSS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/fpss_pkg.sv]
// ----------------------------------------------------------------------------
// Five-point stencil sum package
// Widths and register indexes of the stencil unit; its line stores take their depth from MAX_COLS.
// ----------------------------------------------------------------------------
package fpss_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int SAMPLE_BITS = 32;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int EC_W  = COL_W + 1;
    localparam int ROW_W = 16;
    localparam int SUM_W = SAMPLE_BITS + 3;

    localparam int GRID_ROWS_W = 16;
    localparam int GRID_COLS_W = 11;
    localparam int CFG_DATA_W  = 16;

    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SUM_W + ROW_W + COL_W + 7) / 8) * 8;

    localparam logic [GRID_ROWS_W-1:0] GRID_ROWS_RESET = 16'd1024;
    localparam logic [GRID_COLS_W-1:0] GRID_COLS_RESET = 11'd1024;

    typedef enum logic [0:0] {
        REG_GRID_ROWS = 1'b0,
        REG_GRID_COLS = 1'b1
    } cfg_index_t;

endpackage

[rtl/fpss_ram.sv]
// ----------------------------------------------------------------------------
// Generic line store RAM
// One write port and one read port with registered read data (old data is
// returned when a read and a write hit the same address in one cycle).
// ----------------------------------------------------------------------------
module fpss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/five_point_stencil_sum_unit.sv]
// ----------------------------------------------------------------------------
// Five-point stencil sum unit
// Streams a padded grid in raster order and returns the five-point sum of
// every interior cell, with its row, column and a last-of-grid mark.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Contents
//  s_      | in        | s_tvalid / s_tready   | tdata: sample; tuser: first_of_grid
//  m_      | out       | m_tvalid / m_tready   | tdata: cell_sum, cell_row, cell_col;
//          |           |                       | tlast: last_of_grid
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One sample is taken every cycle while s_tready is high. A sample waits in
// the line store read stage while the stores are read, and its result is
// then written to the output register. The line stores are single-port-read
// RAMs with registered read data; a store that lands on the address read in
// the same cycle is forwarded. Reset is synchronous and needs no clearing
// pass. When the output register is full and not taken, a sample in the
// read stage holds and input stalls.
// ----------------------------------------------------------------------------
`include "five_point_stencil_sum_unit_defines.svh"

module five_point_stencil_sum_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [SAMPLE_BITS-1:0] sample; tdata has no padding bits
    input  logic [fpss_pkg::S_TDATA_W-1:0]        s_tdata,
    // [0] first_of_grid
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [SUM_W-1:0] cell_sum, then cell_row (16), then cell_col, then zero padding
    output logic [fpss_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [0:0]                            cfg_index,
    input  logic [fpss_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int COL_W = fpss_pkg::COL_W;
    localparam int EC_W  = fpss_pkg::EC_W;
    localparam int ROW_W = fpss_pkg::ROW_W;
    localparam int SB    = fpss_pkg::SAMPLE_BITS;
    localparam int SUM_W = fpss_pkg::SUM_W;

    localparam logic [COL_W-1:0] LAST_ADDR = COL_W'(fpss_pkg::MAX_COLS - 1);

    // Configuration.
    logic [fpss_pkg::GRID_ROWS_W-1:0] grid_rows_reg;
    logic [fpss_pkg::GRID_COLS_W-1:0] grid_cols_reg;
    logic [EC_W-1:0]                  eff_cols;

    // Position counters.
    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [EC_W-1:0]  col_inc;
    logic [ROW_W-1:0] row_inc;
    logic             cur_hit;
    logic             cur_last;
    logic             cur_edge;
    logic [COL_W-1:0] right_addr;

    logic s_accept;
    logic adv;

    // Read stage.
    logic                   v1_reg;
    logic [COL_W-1:0]       col1_reg;
    logic [COL_W-1:0]       right1_reg;
    logic [ROW_W-1:0]       row1_reg;
    logic signed [SB-1:0]   sample1_reg;
    logic                   hit1_reg;
    logic                   last1_reg;
    logic                   edge1_reg;

    // Store of the previous request, seen by a read issued in the same cycle.
    logic                   fwd_valid_reg;
    logic [COL_W-1:0]       fwd_col_reg;
    logic signed [SB-1:0]   fwd_mid_reg;
    logic signed [SB-1:0]   fwd_up_reg;

    // Left neighbor: the centre value of the previous request.
    logic signed [SB-1:0]   left_reg;

    logic [SB-1:0]          up_rd, mid_rd, right_rd;
    logic signed [SB-1:0]   up_eff, mid_eff, right_eff;
    logic signed [SUM_W-1:0] sum_comb;

    // Output register.
    logic                   m_valid_reg;
    logic signed [SUM_W-1:0] m_sum_reg;
    logic [ROW_W-1:0]       m_row_reg;
    logic [COL_W-1:0]       m_col_reg;
    logic                   m_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= fpss_pkg::GRID_ROWS_RESET;
            grid_cols_reg <= fpss_pkg::GRID_COLS_RESET;
        end else if (cfg_valid) begin
            unique case (fpss_pkg::cfg_index_t'(cfg_index))
                fpss_pkg::REG_GRID_ROWS: begin
                    grid_rows_reg <= cfg_data[fpss_pkg::GRID_ROWS_W-1:0];
                end
                fpss_pkg::REG_GRID_COLS: begin
                    grid_cols_reg <= cfg_data[fpss_pkg::GRID_COLS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A column register above the store depth acts as the depth; zero acts as one.
    always_comb begin
        if (32'(grid_cols_reg) > 32'(fpss_pkg::MAX_COLS)) begin
            eff_cols = EC_W'(fpss_pkg::MAX_COLS);
        end else if (grid_cols_reg == '0) begin
            eff_cols = EC_W'(1);
        end else begin
            eff_cols = EC_W'(grid_cols_reg);
        end
    end

    assign adv      = v1_reg && (!m_valid_reg || m_tready);
    assign s_tready = !v1_reg || adv;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        cur_col  = s_tuser ? '0 : col_count_reg;
        cur_row  = s_tuser ? '0 : row_count_reg;
        cur_edge = (cur_col == LAST_ADDR);
        right_addr = cur_edge ? '0 : cur_col + COL_W'(1);

        cur_hit = (cur_row >= ROW_W'(2))
               && ({1'b0, cur_row} + 17'd1 <= {1'b0, grid_rows_reg})
               && (cur_col >= COL_W'(1))
               && ({1'b0, cur_col} + EC_W'(2) <= eff_cols);
        cur_last = ({1'b0, cur_row} + 17'd1 == {1'b0, grid_rows_reg})
                && ({1'b0, cur_col} + EC_W'(2) == eff_cols);

        col_inc = {1'b0, cur_col} + EC_W'(1);
        row_inc = cur_row + ROW_W'(1);
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (s_accept) begin
            if (col_inc >= eff_cols) begin
                col_count_next = '0;
                if (grid_rows_reg != '0 && row_inc >= grid_rows_reg) begin
                    row_count_next = '0;
                end else begin
                    row_count_next = row_inc;
                end
            end else begin
                col_count_next = col_inc[COL_W-1:0];
                row_count_next = cur_row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // Line stores. The middle line is kept twice so the centre and the right
    // neighbor come out in the same cycle.
    fpss_ram #(.WIDTH(SB), .DEPTH(fpss_pkg::MAX_COLS)) u_upper_ram (
        .clk   (aclk),
        .we    (adv),
        .waddr (col1_reg),
        .wdata (mid_eff),
        .re    (s_accept),
        .raddr (cur_col),
        .rdata (up_rd)
    );

    fpss_ram #(.WIDTH(SB), .DEPTH(fpss_pkg::MAX_COLS)) u_middle_ram (
        .clk   (aclk),
        .we    (adv),
        .waddr (col1_reg),
        .wdata (sample1_reg),
        .re    (s_accept),
        .raddr (cur_col),
        .rdata (mid_rd)
    );

    fpss_ram #(.WIDTH(SB), .DEPTH(fpss_pkg::MAX_COLS)) u_right_ram (
        .clk   (aclk),
        .we    (adv),
        .waddr (col1_reg),
        .wdata (sample1_reg),
        .re    (s_accept),
        .raddr (right_addr),
        .rdata (right_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            fwd_valid_reg <= 1'b0;
            left_reg      <= '0;
        end else begin
            if (s_accept) begin
                v1_reg <= 1'b1;
            end else if (adv) begin
                v1_reg <= 1'b0;
            end
            if (adv || s_accept) begin
                fwd_valid_reg <= adv && s_accept;
            end
            if (adv) begin
                left_reg <= mid_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            col1_reg    <= cur_col;
            right1_reg  <= right_addr;
            row1_reg    <= cur_row - ROW_W'(1);
            sample1_reg <= s_tdata[SB-1:0];
            hit1_reg    <= cur_hit;
            last1_reg   <= cur_last;
            edge1_reg   <= cur_edge;
        end
        if (adv) begin
            fwd_col_reg <= col1_reg;
            fwd_mid_reg <= sample1_reg;
            fwd_up_reg  <= mid_eff;
        end
    end

    always_comb begin
        up_eff    = (fwd_valid_reg && fwd_col_reg == col1_reg) ? fwd_up_reg : up_rd;
        mid_eff   = (fwd_valid_reg && fwd_col_reg == col1_reg) ? fwd_mid_reg : mid_rd;
        if (edge1_reg) begin
            right_eff = '0;
        end else if (fwd_valid_reg && fwd_col_reg == right1_reg) begin
            right_eff = fwd_mid_reg;
        end else begin
            right_eff = right_rd;
        end
        sum_comb = SUM_W'(up_eff) + SUM_W'(left_reg) + SUM_W'(mid_eff)
                 + SUM_W'(right_eff) + SUM_W'(sample1_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && hit1_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && hit1_reg) begin
            m_sum_reg  <= sum_comb;
            m_row_reg  <= row1_reg;
            m_col_reg  <= col1_reg;
            m_last_reg <= last1_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = fpss_pkg::M_TDATA_W'({m_col_reg, m_row_reg, m_sum_reg});
    assign m_tlast  = m_last_reg;

    // A held output with a sample in the read stage must block input.
    `FPSS_ASSERT_SAME(a_stall_blocks_input, aclk, aresetn,
        v1_reg && m_valid_reg && !m_tready, !s_tready)
    // An interior cell leaving the read stage shows up on the output.
    `FPSS_ASSERT_NEXT(a_hit_reaches_output, aclk, aresetn, adv && hit1_reg, m_valid_reg)
    // Forwarding is only armed while a sample sits in the read stage.
    `FPSS_ASSERT_SAME(a_fwd_needs_sample, aclk, aresetn, fwd_valid_reg, v1_reg)

endmodule
